FILE: design/keyed_expiry_timer_table_assert.svh
// Assertion macros shared by the timer table modules.
`ifndef KEYED_EXPIRY_TIMER_TABLE_ASSERT_SVH
`define KEYED_EXPIRY_TIMER_TABLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define KETT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define KETT_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define KETT_ASSERT(label, clk, rst, prop, msg)
`define KETT_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

FILE: design/kett_pkg.sv
`timescale 1ns / 1ps
package kett_pkg;
   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_SET    = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_QUERY  = 2'd3;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_IGNORED = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_ABSENT  = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] item_key;
      logic [15:0] duration;
      logic [7:0]  partial_tick;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        present;
      logic        active;
      logic [15:0] ticks_left;
      logic [16:0] progress;
      logic [4:0]  freed_count;
   } rsp_type;

   // divider control
   typedef struct packed {
      logic        start;
      logic [49:0] dividend;
      logic [31:0] divisor;
   } div_req_type;
endpackage

FILE: design/kett_if.sv
`timescale 1ns / 1ps
interface kett_req_if import kett_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface kett_rsp_if import kett_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: design/keyed_expiry_timer_table.sv
`timescale 1ns / 1ps
// Keyed expiry timer table.
// Channels: req (op, item_key, duration, partial_tick) in, rsp (status, present,
// active, ticks_left, progress, freed_count) out, valid/ready on each, a
// transaction moves when both are high. Every request gives exactly one response.
// Operations: tick advances the 32-bit counter and frees expired entries; set
// creates or rewrites a key's countdown; remove frees it; query reports presence,
// activity, whole ticks left and Q1.16 progress.
// Scan: each request that is not ignored scans every slot of the table, one slot per
// cycle out of the slot memory (registered read); a query that hits then fetches the
// entry and, unless the progress is zero, runs a 50-step restoring divide and waits
// for its done strobe. The memory scan and the serial divider set the rate; one
// request is in flight at a time.
// Reset clears the counter and all used bits (flops), at once; no clearing pass.
// The response waits in an output register; while the receiver stalls it holds,
// and the next request is taken only after the response has left.
`include "keyed_expiry_timer_table_assert.svh"
module keyed_expiry_timer_table import kett_pkg::*; #(
   parameter int SLOTS = 16,
   parameter int KEY_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   kett_req_if.sink   req,
   kett_rsp_if.source rsp
);
   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int EW = KEY_BITS + 64;
   localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_APPLY = 3'd2,
                          S_QRD = 3'd3, S_QCALC = 3'd4, S_DIV = 3'd5, S_OUT = 3'd6;

   logic [2:0]          state_ff, state_in;
   req_type             cur_ff, cur_in;
   logic [31:0]         now_ff, now_in;
   logic [SLOTS-1:0]    used_ff, used_in;
   logic [AW:0]         idx_ff, idx_in;      // read address issued
   logic [AW:0]         chk_ff, chk_in;      // slot whose data is on rd_data
   logic                chk_v_ff, chk_v_in;
   logic                hit_ff, hit_in;
   logic [AW-1:0]       hit_idx_ff, hit_idx_in;
   logic                free_ff, free_in;
   logic [AW-1:0]       free_idx_ff, free_idx_in;
   logic [4:0]          freed_ff, freed_in;
   rsp_type             out_ff, out_in;
   logic                rv_ff, rv_in;
   logic [31:0]         total_ff, total_in;
   logic                prog_zero_ff, prog_zero_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr, rd_addr;
   logic [EW-1:0]       wr_data, rd_data;
   logic [KEY_BITS-1:0] key_m, rd_key;
   logic [31:0]         rd_start, rd_end, d_now, d_tot;
   logic [41:0]         rem;
   div_req_type         dctl;
   logic                dbusy, ddone;
   logic [17:0]         quo;

   kett_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data));

   kett_div u_div (.clock(clock), .reset(reset), .ctrl(dctl), .busy(dbusy),
      .done(ddone), .quotient(quo));

   assign key_m    = KEY_BITS'(cur_ff.item_key);
   assign rd_key   = rd_data[EW-1 -: KEY_BITS];
   assign rd_start = rd_data[63:32];
   assign rd_end   = rd_data[31:0];
   assign d_now    = rd_end - now_ff;
   assign d_tot    = rd_end - rd_start;
   assign rd_addr  = (state_ff == S_QCALC || state_ff == S_QRD) ? hit_idx_ff
                                                             : idx_ff[AW-1:0];
   assign rem = {{2{d_now[31]}}, d_now, 8'd0} - {34'd0, cur_ff.partial_tick};

   assign req.ready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp.valid = rv_ff;
   assign rsp.payload = out_ff;

   always_comb begin
      state_in = state_ff; cur_in = cur_ff; now_in = now_ff; used_in = used_ff;
      idx_in = idx_ff; chk_in = chk_ff; chk_v_in = 1'b0; hit_in = hit_ff;
      hit_idx_in = hit_idx_ff; free_in = free_ff; free_idx_in = free_idx_ff;
      freed_in = freed_ff; out_in = out_ff; rv_in = rv_ff; total_in = total_ff;
      prog_zero_in = prog_zero_ff;
      wr_en = 1'b0; wr_addr = hit_idx_ff; wr_data = {key_m, now_ff, now_ff};
      dctl = '0;
      dctl.dividend = {rem[41:0], 8'd0};
      dctl.divisor = total_ff;
      if (rv_ff && rsp.ready) rv_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               cur_in = req.payload;
               out_in = '0;
               idx_in = '0; hit_in = 1'b0; free_in = 1'b0; freed_in = '0;
               if (req.payload.op == OP_TICK) begin
                  now_in = now_ff + 32'd1;
                  state_in = S_SCAN;
               end else if (KEY_BITS'(req.payload.item_key) == '0 ||
                            (req.payload.op == OP_SET && req.payload.duration == 16'd0)) begin
                  out_in.status = ST_IGNORED;
                  state_in = S_OUT;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (idx_ff < (AW+1)'(SLOTS)) begin
               chk_in = idx_ff; chk_v_in = 1'b1; idx_in = idx_ff + 1'b1;
            end
            if (chk_v_ff) begin
               if (cur_ff.op == OP_TICK) begin
                  if (used_ff[chk_ff[AW-1:0]] && ($signed(rd_end - now_ff) <= 0)) begin
                     used_in[chk_ff[AW-1:0]] = 1'b0;
                     freed_in = freed_ff + 5'd1;
                  end
               end else begin
                  if (used_ff[chk_ff[AW-1:0]] && rd_key == key_m && !hit_ff) begin
                     hit_in = 1'b1; hit_idx_in = chk_ff[AW-1:0];
                  end
               end
            end
            if (!chk_v_ff && idx_ff == (AW+1)'(SLOTS)) state_in = S_APPLY;
            if (chk_v_ff && chk_ff == (AW+1)'(SLOTS-1)) state_in = S_APPLY;
            // free slot search needs no memory
            if (!free_ff) begin
               for (int i = SLOTS-1; i >= 0; i--) begin
                  if (!used_ff[i]) free_idx_in = AW'(i);
               end
               free_in = ~&used_ff;
            end
         end
         S_APPLY: begin
            out_in.status = ST_DONE;
            state_in = S_OUT;
            case (cur_ff.op)
               OP_TICK: out_in.freed_count = freed_ff;
               OP_SET: begin
                  if (hit_ff || free_ff) begin
                     wr_en = 1'b1;
                     wr_addr = hit_ff ? hit_idx_ff : free_idx_ff;
                     wr_data = {key_m, now_ff, now_ff + {16'd0, cur_ff.duration}};
                     used_in[wr_addr] = 1'b1;
                  end else begin
                     out_in.status = ST_FULL;
                  end
               end
               OP_REMOVE: begin
                  if (hit_ff) used_in[hit_idx_ff] = 1'b0;
                  else out_in.status = ST_ABSENT;
               end
               default: begin
                  if (hit_ff) state_in = S_QRD;
                  else out_in.status = ST_ABSENT;
               end
            endcase
         end
         S_QRD: state_in = S_QCALC;
         S_QCALC: begin
            out_in.present = 1'b1;
            if (!d_now[31] && d_now != 32'd0) begin
               out_in.active = 1'b1;
               out_in.ticks_left = (d_now > 32'd65535) ? 16'hFFFF : d_now[15:0];
            end
            total_in = d_tot;
            prog_zero_in = d_tot[31] || d_tot == 32'd0 || rem[41] || rem == 42'd0;
            if (d_tot[31] || d_tot == 32'd0 || rem[41] || rem == 42'd0) begin
               state_in = S_OUT;
            end else begin
               dctl.start = 1'b1;
               dctl.divisor = d_tot;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (ddone) begin
               out_in.progress = (quo > 18'd65536) ? 17'h10000 : quo[16:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; now_ff <= '0; used_ff <= '0; rv_ff <= 1'b0;
         chk_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in; now_ff <= now_in; used_ff <= used_in; rv_ff <= rv_in;
         chk_v_ff <= chk_v_in;
      end
      cur_ff <= cur_in; idx_ff <= idx_in; chk_ff <= chk_in; hit_ff <= hit_in;
      hit_idx_ff <= hit_idx_in; free_ff <= free_in; free_idx_ff <= free_idx_in;
      freed_ff <= freed_in; out_ff <= out_in; total_ff <= total_in;
      prog_zero_ff <= prog_zero_in;
   end

   `KETT_ASSERT(a_one_in_flight, clock, reset, req.valid && req.ready |=> !rv_ff, "early accept")
   `KETT_ASSERT(a_div_only_query, clock, reset, dbusy |-> cur_ff.op == OP_QUERY && !prog_zero_ff, "stray divide")
   `KETT_ASSERT(a_freed_tick, clock, reset, rv_ff && out_ff.freed_count != 5'd0 |-> cur_ff.op == OP_TICK, "stray freed")
   `KETT_ASSERT_NR(a_reset_idle, clock, reset |=> state_ff == S_IDLE && !rv_ff, "reset did not idle")
endmodule

FILE: design/kett_ram.sv
`timescale 1ns / 1ps
module kett_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

FILE: design/kett_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle; the quotient reads all ones once it
// overflows 18 bits.
`include "keyed_expiry_timer_table_assert.svh"
module kett_div import kett_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type ctrl,
   output logic        busy,
   output logic        done,
   output logic [17:0] quotient
);
   localparam int NB = 50;
   logic [NB-1:0] num_ff, num_in;
   logic [32:0]   rem_ff, rem_in;
   logic [31:0]   den_ff, den_in;
   logic [17:0]   quo_ff, quo_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic          big_ff, big_in;
   logic [33:0]   trial;
   logic [32:0]   shifted;

   always_comb begin
      num_in = num_ff; rem_in = rem_ff; den_in = den_ff; quo_in = quo_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0; big_in = big_ff;
      shifted = {rem_ff[31:0], num_ff[NB-1]};
      trial = {1'b0, shifted} - {2'b0, den_ff};
      if (ctrl.start) begin
         num_in = ctrl.dividend; den_in = ctrl.divisor; rem_in = '0;
         quo_in = '0; cnt_in = 6'(NB); busy_in = 1'b1; big_in = 1'b0;
      end else if (busy_ff) begin
         num_in = {num_ff[NB-2:0], 1'b0};
         if (!trial[33]) begin
            rem_in = trial[32:0];
            if (quo_ff[17]) big_in = 1'b1;
            quo_in = {quo_ff[16:0], 1'b1};
         end else begin
            rem_in = shifted;
            if (quo_ff[17]) big_in = 1'b1;
            quo_in = {quo_ff[16:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0; big_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in; big_ff <= big_in;
      end
      num_ff <= num_in; rem_ff <= rem_in; den_ff <= den_in; quo_ff <= quo_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quotient = big_ff ? 18'h3FFFF : quo_ff;

   `KETT_ASSERT(a_done_after_busy, clock, reset, done |-> $past(busy_ff), "done without busy")
   `KETT_ASSERT(a_no_restart, clock, reset, busy_ff |-> !ctrl.start, "divider restarted")
   `KETT_ASSERT(a_busy_count, clock, reset, busy_ff |-> cnt_ff != 6'd0, "busy with zero count")
endmodule
